[rtl/core/modular_inverse_extended_euclid_macros.svh]
// Assertion macros for the modular inverse checker.
`ifndef MODULAR_INVERSE_EXTENDED_EUCLID_MACROS_SVH
`define MODULAR_INVERSE_EXTENDED_EUCLID_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define MIE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mie_checker: same-cycle property failed");

// Next-cycle implication, disabled while in reset.
`define MIE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mie_checker: next-cycle property failed");

`endif

[rtl/core/mie_pkg.sv]
// Shared widths, types and control structs of the modular inverse block.
package mie_pkg;

   localparam int VALUE_BITS = 31;
   // coefficients stay within +/- modulus; the product term within twice that
   localparam int COEF_BITS  = VALUE_BITS + 3;
   localparam int SHIFT_BITS = $clog2(VALUE_BITS);

   typedef logic [VALUE_BITS-1:0]       value_type;
   typedef logic signed [COEF_BITS-1:0] coef_type;

   typedef struct packed {
      logic load;
      logic start;
      logic align;
      logic divide;
      logic fix_neg;
      logic fix_hi;
   } ctl_type;

   typedef struct packed {
      logic a_le_one;
      logic b_zero;
      logic shift_ok;
      logic last;
      logic qbit;
   } div_status_type;

endpackage

[rtl/core/mie_req_if.sv]
// Request channel: value and modulus with valid/ready handshake.
interface mie_req_if;
   import mie_pkg::*;

   logic      valid;
   logic      ready;
   value_type value;
   value_type modulus;

   modport source (output valid, output value, output modulus, input ready);
   modport sink (input valid, input value, input modulus, output ready);
endinterface

[rtl/core/mie_rsp_if.sv]
// Response channel: inverse and status with valid/ready handshake.
interface mie_rsp_if;
   import mie_pkg::*;

   logic      valid;
   logic      ready;
   value_type inverse;
   logic      status;

   modport source (output valid, output inverse, output status, input ready);
   modport sink (input valid, input inverse, input status, output ready);
endinterface

[rtl/core/mie_divider.sv]
// Shift-subtract divider holding the Euclid remainder pair, one quotient bit per cycle.
module mie_divider (
   input  logic                    clock,
   input  mie_pkg::ctl_type        ctl,
   input  mie_pkg::value_type      value,
   input  mie_pkg::value_type      modulus,
   output mie_pkg::div_status_type status
);
   import mie_pkg::*;

   value_type             a_ff, a_in;
   value_type             b_ff, b_in;
   value_type             d_ff, d_in;
   logic [SHIFT_BITS-1:0] k_ff, k_in;
   logic [VALUE_BITS:0]   d_dbl;
   logic                  ge;
   value_type             rem;

   assign d_dbl = {d_ff, 1'b0};
   assign ge    = (a_ff >= d_ff);
   assign rem   = ge ? (a_ff - d_ff) : a_ff;

   assign status.a_le_one = (a_ff <= value_type'(1));
   assign status.b_zero   = (b_ff == '0);
   assign status.shift_ok = (d_dbl <= {1'b0, a_ff});
   assign status.last     = (k_ff == '0);
   assign status.qbit     = ge;

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      d_in = d_ff;
      k_in = k_ff;
      if (ctl.load) begin
         a_in = value;
         b_in = modulus;
      end else if (ctl.start) begin
         d_in = b_ff;
         k_in = '0;
      end else if (ctl.align) begin
         if (status.shift_ok) begin
            d_in = d_dbl[VALUE_BITS-1:0];
            k_in = k_ff + 1'b1;
         end
      end else if (ctl.divide) begin
         d_in = d_ff >> 1;
         k_in = k_ff - 1'b1;
         // last quotient bit: the divisor becomes the dividend, the remainder the divisor
         if (status.last) begin
            a_in = b_ff;
            b_in = rem;
         end else begin
            a_in = rem;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      d_ff <= d_in;
      k_ff <= k_in;
   end

endmodule

[rtl/core/mie_coef.sv]
// Bezout coefficient unit: serial quotient multiply-accumulate and final correction.
module mie_coef (
   input  logic                    clock,
   input  mie_pkg::ctl_type        ctl,
   input  mie_pkg::value_type      modulus,
   input  mie_pkg::div_status_type dstat,
   output mie_pkg::value_type      inverse
);
   import mie_pkg::*;

   coef_type  x_ff, x_in;
   coef_type  y_ff, y_in;
   coef_type  acc_ff, acc_in;
   coef_type  acc_next;
   coef_type  m0_ext;
   value_type m0_ff, m0_in;

   assign m0_ext   = {{(COEF_BITS-VALUE_BITS){1'b0}}, m0_ff};
   // quotient bits arrive MSB first, so q*y builds up as acc = 2*acc + bit*y
   assign acc_next = (acc_ff <<< 1) + (dstat.qbit ? y_ff : coef_type'(0));
   assign inverse  = x_ff[VALUE_BITS-1:0];

   always_comb begin
      x_in   = x_ff;
      y_in   = y_ff;
      acc_in = acc_ff;
      m0_in  = m0_ff;
      if (ctl.load) begin
         x_in  = coef_type'(1);
         y_in  = coef_type'(0);
         m0_in = modulus;
      end else if (ctl.start) begin
         acc_in = coef_type'(0);
      end else if (ctl.divide) begin
         acc_in = acc_next;
         if (dstat.last) begin
            x_in = y_ff;
            y_in = x_ff - acc_next;
         end
      end else if (ctl.fix_neg) begin
         if (x_ff[COEF_BITS-1]) begin
            x_in = x_ff + m0_ext;
         end
      end else if (ctl.fix_hi) begin
         if (x_ff >= m0_ext) begin
            x_in = x_ff - m0_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
      m0_ff  <= m0_in;
   end

endmodule

[rtl/core/modular_inverse_extended_euclid.sv]
// Modular inverse by the extended Euclidean algorithm, top level with sequencer.
//
// A request on req_chan carries value and modulus; the response on rsp_chan
// carries inverse and status (1 when the value has no inverse).
// One request is in work at a time; req_chan.ready is high while idle.
// Modulus 1, value 0 or modulus 0 go straight to the done state. Otherwise
// the block runs one Euclid step per quotient, then corrects the sign and
// range of the coefficient; a common factor ends early.
// The divider aligns the divisor one bit per cycle, then takes one quotient
// bit per cycle with one subtract and one accumulate of the coefficient.
// A finished result sits in the output register, so the next request is
// accepted while the response waits; if that one finishes before the
// response is taken, it holds in its last state until the register frees.
// Reset is synchronous: the block goes idle and drops rsp_chan.valid.
module modular_inverse_extended_euclid (
   input logic      clock,
   input logic      reset,
   mie_req_if.sink  req_chan,
   mie_rsp_if.source rsp_chan
);
   import mie_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CHECK  = 3'd1;
   localparam logic [2:0] S_ALIGN  = 3'd2;
   localparam logic [2:0] S_DIVIDE = 3'd3;
   localparam logic [2:0] S_FIXNEG = 3'd4;
   localparam logic [2:0] S_FIXHI  = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   logic [2:0]     state_ff, state_in;
   logic           res_zero_ff, res_zero_in;
   logic           res_fail_ff, res_fail_in;
   logic           rsp_valid_ff, rsp_valid_in;
   value_type      rsp_inverse_ff, rsp_inverse_in;
   logic           rsp_status_ff, rsp_status_in;
   logic           out_load;
   logic           mod_one;
   logic           special;
   ctl_type        ctl;
   div_status_type dstat;
   value_type      coef_inverse;

   mie_divider u_divider (
      .clock   (clock),
      .ctl     (ctl),
      .value   (req_chan.value),
      .modulus (req_chan.modulus),
      .status  (dstat)
   );

   mie_coef u_coef (
      .clock   (clock),
      .ctl     (ctl),
      .modulus (req_chan.modulus),
      .dstat   (dstat),
      .inverse (coef_inverse)
   );

   assign mod_one = (req_chan.modulus == value_type'(1));
   assign special = mod_one || (req_chan.value == '0) || (req_chan.modulus == '0);

   assign req_chan.ready   = (state_ff == S_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.inverse = rsp_inverse_ff;
   assign rsp_chan.status  = rsp_status_ff;

   always_comb begin
      ctl         = '0;
      state_in    = state_ff;
      res_zero_in = res_zero_ff;
      res_fail_in = res_fail_ff;
      out_load    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               ctl.load = 1'b1;
               if (special) begin
                  res_zero_in = 1'b1;
                  res_fail_in = !mod_one;
                  state_in    = S_DONE;
               end else begin
                  res_zero_in = 1'b0;
                  res_fail_in = 1'b0;
                  state_in    = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (dstat.a_le_one) begin
               state_in = S_FIXNEG;
            end else if (dstat.b_zero) begin
               // zero remainder with divisor above one: common factor
               res_zero_in = 1'b1;
               res_fail_in = 1'b1;
               state_in    = S_DONE;
            end else begin
               ctl.start = 1'b1;
               state_in  = S_ALIGN;
            end
         end
         S_ALIGN: begin
            ctl.align = 1'b1;
            if (!dstat.shift_ok) begin
               state_in = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            ctl.divide = 1'b1;
            if (dstat.last) begin
               state_in = S_CHECK;
            end
         end
         S_FIXNEG: begin
            ctl.fix_neg = 1'b1;
            state_in    = S_FIXHI;
         end
         S_FIXHI: begin
            ctl.fix_hi = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_inverse_in = rsp_inverse_ff;
      rsp_status_in  = rsp_status_ff;
      if (out_load) begin
         rsp_inverse_in = res_zero_ff ? value_type'(0) : coef_inverse;
         rsp_status_in  = res_fail_ff;
         rsp_valid_in   = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         res_zero_ff  <= 1'b0;
         res_fail_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         res_zero_ff  <= res_zero_in;
         res_fail_ff  <= res_fail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_inverse_ff <= rsp_inverse_in;
      rsp_status_ff  <= rsp_status_in;
   end

endmodule

[rtl/core/mie_checker.sv]
// Port-level checker for the modular inverse block, with its bind.
`include "modular_inverse_extended_euclid_macros.svh"

module mie_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input mie_pkg::value_type rsp_inverse,
   input logic               rsp_status
);
   import mie_pkg::*;

   `MIE_ASSERT_NEXT(rsp_valid_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `MIE_ASSERT_NEXT(rsp_data_held, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_inverse) && $stable(rsp_status))
   // one request in work at a time
   `MIE_ASSERT_NEXT(one_in_work, clock, reset, req_valid && req_ready, !req_ready)
   // a value without inverse reports zero
   `MIE_ASSERT_NOW(fail_gives_zero, clock, reset, rsp_valid && rsp_status, rsp_inverse == value_type'(0))

endmodule

bind modular_inverse_extended_euclid mie_checker u_mie_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_inverse (rsp_chan.inverse),
   .rsp_status  (rsp_chan.status)
);

[verif/tb.sv]
// Testbench for the modular inverse block: scoreboard, request driver and response sink.
module tb;
   import mie_pkg::*;

   localparam value_type   VALUE_MAX   = '1;
   localparam int unsigned RANDOM_REQS = 750;
   localparam int unsigned IDLE_LIMIT  = 5000;
   localparam int unsigned LONG_HOLD   = 1500;
   localparam int unsigned SETTLE      = 250;

   typedef struct packed {
      value_type inverse;
      logic      status;
   } inverse_result_type;

   class inverse_scoreboard;
      inverse_result_type expected_results[$];
      int unsigned        mismatches = 0;

      // Extended Euclid with 64-bit wrapping coefficients.
      function inverse_result_type predict_inverse(value_type value, value_type modulus);
         logic [63:0]        a, b, q, r, x, y, t, m0;
         inverse_result_type res;
         a = 64'(value);
         b = 64'(modulus);
         m0 = b;
         x = 64'd1;
         y = 64'd0;
         res.inverse = '0;
         res.status = 1'b0;
         if (m0 == 64'd1) return res;
         if (a == 64'd0 || m0 == 64'd0) begin
            res.status = 1'b1;
            return res;
         end
         while (a > 64'd1) begin
            // zero remainder with divisor above one: shared factor
            if (b == 64'd0) begin
               res.status = 1'b1;
               return res;
            end
            q = a / b;
            r = a % b;
            a = b;
            b = r;
            t = y;
            y = x - q * y;
            x = t;
         end
         if (x[63]) x = x + m0;
         if (x >= m0) x = x % m0;
         res.inverse = x[VALUE_BITS-1:0];
         return res;
      endfunction

      function void note_request(value_type value, value_type modulus);
         expected_results.insert(expected_results.size(), predict_inverse(value, modulus));
      endfunction

      function void check_response(value_type inverse, logic status);
         inverse_result_type want;
         if (expected_results.size() == 0) begin
            $error("response with no request pending: inverse %0d status %0b", inverse, status);
            mismatches++;
            return;
         end
         want = expected_results.pop_front();
         if (inverse !== want.inverse) begin
            $error("inverse: expected %0d, actual %0d", want.inverse, inverse);
            mismatches++;
         end
         if (status !== want.status) begin
            $error("status: expected %0b, actual %0b", want.status, status);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_results.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   mie_req_if req_bus();
   mie_rsp_if rsp_bus();

   modular_inverse_extended_euclid DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   inverse_scoreboard sb = new();
   int unsigned       accepted_requests = 0;
   int unsigned       quiet_cycles = 0;
   int unsigned       burst_left = 0;
   int unsigned       prime_moduli[6] = '{2, 3, 251, 65521, 1000003, 2147483647};

   always #5 clock = ~clock;

   always @(posedge clock) begin : monitor
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            sb.note_request(req_bus.value, req_bus.modulus);
            accepted_requests++;
         end
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_response(rsp_bus.inverse, rsp_bus.status);
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Response sink: segments of always-ready, random and periodic stalls, plus one long hold.
   initial begin : receiver
      int unsigned mode, span, phase;
      bit          held;
      held = 1'b0;
      phase = 0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!held && accepted_requests >= 150) begin
            held = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(4, 80);
         repeat (span) begin
            case (mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= 1'($urandom_range(0, 1));
               2: rsp_bus.ready <= (phase % 3 == 0);
               default: rsp_bus.ready <= ($urandom_range(0, 7) != 0);
            endcase
            phase++;
            @(posedge clock);
         end
      end
   end

   // Offer one request, opening a new burst after a random gap when the current one is used up.
   task automatic offer(value_type v, value_type m);
      logic took;
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                  : $urandom_range(1, 25);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= v;
      req_bus.modulus <= m;
      // ready only moves on the rising edge, so the falling edge shows what the next edge sees
      do begin
         @(negedge clock);
         took = req_bus.ready;
         @(posedge clock);
      end while (!took);
      burst_left--;
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic send_directed();
      offer(0, 1);
      offer(12345, 1);
      offer(VALUE_MAX, 1);
      offer(0, 7);
      offer(0, VALUE_MAX);
      offer(5, 0);
      offer(0, 0);
      offer(1, 2);
      offer(3, 7);
      offer(10, 7);
      offer(7, 7);
      offer(6, 9);
      offer(VALUE_MAX, VALUE_MAX);
      offer(1, VALUE_MAX);
      offer(2, VALUE_MAX);
      offer(VALUE_MAX - 1, VALUE_MAX);
      offer(VALUE_MAX, VALUE_MAX - 1);
      // consecutive Fibonacci numbers give the longest Euclid chain
      offer(1836311903, 1134903170);
      offer(1134903170, 1836311903);
      offer(31'h5555_5555, 31'h2aaa_aaaa);
      offer(31'h4000_0000, 3);
      offer(65520, 65521);
   endtask

   function automatic void pick_operands(output value_type v, output value_type m);
      int unsigned kind, g;
      kind = $urandom_range(0, 99);
      g = $urandom_range(2, 5000);
      if (kind < 45) begin
         v = value_type'($urandom);
         m = value_type'($urandom);
      end else if (kind < 60) begin
         v = value_type'($urandom_range(0, 300));
         m = value_type'($urandom_range(2, 300));
      end else if (kind < 75) begin
         m = value_type'(prime_moduli[$urandom_range(0, 5)]);
         v = value_type'($urandom) % m;
      end else if (kind < 87) begin
         m = value_type'(g * $urandom_range(1, VALUE_MAX / g));
         v = value_type'(g * $urandom_range(0, VALUE_MAX / g));
      end else if (kind < 93) begin
         m = value_type'($urandom_range(2, 1000));
         v = value_type'($urandom);
      end else if (kind < 96) begin
         m = value_type'(1);
         v = value_type'($urandom);
      end else if (kind < 98) begin
         m = value_type'($urandom);
         v = value_type'(0);
      end else begin
         m = value_type'(0);
         v = value_type'($urandom);
      end
   endfunction

   initial begin : stimulus
      value_type v, m;
      req_bus.valid <= 1'b0;
      req_bus.value <= '0;
      req_bus.modulus <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      send_directed();
      drain();
      for (int i = 0; i < RANDOM_REQS; i++) begin
         if (i == RANDOM_REQS / 2) drain();
         pick_operands(v, m);
         offer(v, m);
      end
      drain();
      repeat (SETTLE) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d responses never arrived", sb.pending());
         sb.mismatches++;
      end
      if (sb.mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/mie_pkg.sv
rtl/core/mie_req_if.sv
rtl/core/mie_rsp_if.sv
rtl/core/mie_divider.sv
rtl/core/mie_coef.sv
rtl/core/modular_inverse_extended_euclid.sv
rtl/core/mie_checker.sv
verif/tb.sv
